// ===== hdl/sil_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sorted insert list.
// No dependencies; imported by sil_cell and sorted_insert_list_top.
package sil_pkg;

   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int DEPTH_DEF     = 16;
   localparam int KEY_WIDTH_DEF = 32;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;   // place the broadcast key
      logic rot;   // rotate the occupied cells one place toward the head
   } sil_ctl_type;

endpackage

// ===== hdl/sil_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the sorted key chain: holds a key and an occupied flag.
// Depends on sil_pkg for the control struct.
module sil_cell #(
   parameter int KEY_WIDTH = sil_pkg::KEY_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sil_pkg::sil_ctl_type ctl,
   input  logic [KEY_WIDTH-1:0] new_key,
   input  logic [KEY_WIDTH-1:0] head_key,
   input  logic [KEY_WIDTH-1:0] prev_key,
   input  logic                 prev_valid,
   input  logic                 prev_take,
   input  logic [KEY_WIDTH-1:0] next_key,
   input  logic                 next_valid,
   output logic [KEY_WIDTH-1:0] key,
   output logic                 valid,
   output logic                 take
);
   import sil_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 valid_ff, valid_in;

   // Empty cells and keys not smaller than the new one give way.
   assign take = !valid_ff || ($signed(key_ff) >= $signed(new_key));

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.ins) begin
         if (prev_take) begin
            if (prev_valid) begin
               key_in   = prev_key;
               valid_in = 1'b1;
            end
         end else if (take) begin
            key_in   = new_key;
            valid_in = 1'b1;
         end
      end else if (ctl.rot && valid_ff) begin
         // the tail of the occupied run wraps back to the head key
         key_in = next_valid ? next_key : head_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key   = key_ff;
   assign valid = valid_ff;

endmodule

// ===== hdl/sorted_insert_list_top.sv =====
`timescale 1ns / 1ps
// Top level of the sorted insert list: command handshake, read-out sequencer
// and the chain of sil_cell instances. Depends on sil_pkg and sil_cell.

// An insert does not raise busy, so a new item may follow in the next cycle; its
// single status beat appears on the rsp_ ports the cycle after acceptance.
// A read-out of n stored keys holds busy high while it delivers n entry
// beats: acceptance sets the read-out state, and each beat is registered from
// the head key. The chain rotates one place per cycle, so n rotations return it
// to its order. The next item is taken as soon as busy is low.
// A read-out of an empty list gives a single beat. Result beats are
// strobed by rsp_valid for exactly one cycle and must be taken: there is no
// stall from the receiver. No clearing pass follows reset.
module sorted_insert_list_top #(
   parameter int DEPTH     = sil_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = sil_pkg::KEY_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic signed [sil_pkg::VALUE_W-1:0]  req_value,
   output logic                          rsp_valid,
   output logic signed [sil_pkg::VALUE_W-1:0]  rsp_key_out,
   output logic [sil_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);
   import sil_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [KEY_WIDTH-1:0] cell_key [DEPTH];
   logic [DEPTH-1:0]     cell_valid;
   logic [DEPTH-1:0]     cell_take;
   logic [KEY_WIDTH-1:0] new_key;
   logic [VALUE_W-1:0]   head_out;
   sil_ctl_type          ctl;

   logic                 accept, full;
   logic [CNT_W-1:0]     key_count_ff, key_count_in;
   logic                 rd_active_ff, rd_active_in;
   logic [CNT_W-1:0]     rd_left_ff, rd_left_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_key_ff, rsp_key_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Fit the request value to the key width and the head key to the port.
   generate
      if (KEY_WIDTH <= VALUE_W) begin : g_narrow
         assign new_key  = req_value[KEY_WIDTH-1:0];
         assign head_out = VALUE_W'(cell_key[0]);
      end else begin : g_wide
         assign new_key  = {{(KEY_WIDTH - VALUE_W){1'b0}}, req_value};
         assign head_out = cell_key[0][VALUE_W-1:0];
      end
   endgenerate

   assign busy   = rd_active_ff;
   assign accept = start && !busy;
   assign full   = cell_valid[DEPTH-1];

   assign ctl.ins = accept && (req_func == FUNC_INSERT) && !full;
   assign ctl.rot = rd_active_ff;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [KEY_WIDTH-1:0] prev_key, next_key;
         logic                 prev_valid, prev_take, next_valid;
         if (i == 0) begin : g_first
            assign prev_key   = '0;
            assign prev_valid = 1'b0;
            assign prev_take  = 1'b0;
         end else begin : g_mid
            assign prev_key   = cell_key[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_take  = cell_take[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign next_key   = '0;
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_key   = cell_key[i+1];
            assign next_valid = cell_valid[i+1];
         end
         sil_cell #(
            .KEY_WIDTH (KEY_WIDTH)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .new_key    (new_key),
            .head_key   (cell_key[0]),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .prev_take  (prev_take),
            .next_key   (next_key),
            .next_valid (next_valid),
            .key        (cell_key[i]),
            .valid      (cell_valid[i]),
            .take       (cell_take[i])
         );
      end
   endgenerate

   always_comb begin
      key_count_in  = key_count_ff;
      rd_active_in  = rd_active_ff;
      rd_left_in    = rd_left_ff;
      rsp_valid_in  = 1'b0;
      rsp_key_in    = '0;
      rsp_status_in = ST_INSERTED;
      rsp_last_in   = 1'b1;
      if (rd_active_ff) begin
         // stream the head key while the chain rotates
         rsp_valid_in  = 1'b1;
         rsp_key_in    = head_out;
         rsp_status_in = ST_ENTRY;
         rsp_last_in   = (rd_left_ff == CNT_W'(1));
         rd_left_in    = rd_left_ff - CNT_W'(1);
         if (rd_left_ff == CNT_W'(1)) begin
            rd_active_in = 1'b0;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_func == FUNC_INSERT) begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_status_in = ST_INSERTED;
               key_count_in  = key_count_ff + CNT_W'(1);
            end
         end else if (key_count_ff == '0) begin
            rsp_status_in = ST_EMPTY;
         end else begin
            rsp_valid_in = 1'b0;
            rd_active_in = 1'b1;
            rd_left_in   = key_count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         rd_active_ff <= 1'b0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         rd_active_ff <= rd_active_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      key_count_ff <= CNT_W'(DEPTH))
      else $error("key count above depth");

   a_count_matches_chain : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(key_count_ff))
      else $error("occupied cells disagree with key count");

   a_read_left : assert property (@(posedge clock) disable iff (reset)
      rd_active_ff |-> (rd_left_ff != '0))
      else $error("read-out active with nothing left");

   a_full_reject : assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_INSERT && full) |=>
         (rsp_valid && rsp_status == ST_FULL && $stable(key_count_ff)))
      else $error("insert into full list not rejected");
`endif

endmodule
